### rtl/core/fragment_reassembly_tracker_top_defines.svh
// Assertion macros for the fragment reassembly tracker.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTH
`define FRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fragment tracker assertion failed");
`define FRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fragment tracker assertion failed");
`else
`define FRT_ASSERT_NOW(label, ante, cons)
`define FRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/frt_pkg.sv
// Types and constants shared by the fragment reassembly tracker.
`default_nettype none

package frt_pkg;

    localparam int MAX_FRAGMENTS = 64;
    localparam int IDX_W         = $clog2(MAX_FRAGMENTS);
    localparam int CNT_W         = 7;
    localparam int ID_W          = 64;
    localparam int FIDX_W        = 15;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DONE  = 3'd1,
        ST_DUP   = 3'd2,
        ST_RANGE = 3'd3,
        ST_BAD   = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   message_id;
        logic [FIDX_W-1:0] frag_index;
        logic              is_final;
    } frag_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   arrived_count;
        logic [CNT_W-1:0]   expected_total;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/fragment_reassembly_tracker_top.sv
// Top level of the fragment reassembly tracker: header register, tracking state, result register.
`default_nettype none
`include "fragment_reassembly_tracker_top_defines.svh"

// Tracks which fragments of one message have arrived, taking one fragment header
// per item. A header is captured in an input register and checked against the
// tracking state (current id, 64-bit arrival map, count, highest index, expected
// total) when the result register is free to take its status, which is written
// there on the same edge as the tracking state is updated.
// With the result side ready, a new header is accepted every cycle; the rate is
// set by the combinational loop through the arrival map bit test and the count and
// total update. A result that waits stalls the input once the input register
// also holds a header.
module fragment_reassembly_tracker_top
    import frt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    frag_valid,
    output logic         frag_ready,
    input  wire frag_t   frag,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic                     hold_valid_reg;
    frag_t                    hold_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic                     have_reg;
    logic [ID_W-1:0]          cur_id_reg;
    logic [MAX_FRAGMENTS-1:0] map_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         highest_reg;
    logic [CNT_W-1:0]         total_reg;

    logic                     have_next;
    logic [MAX_FRAGMENTS-1:0] map_next;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         highest_next;
    logic [CNT_W-1:0]         total_next;
    result_t                  result_next;

    logic                     out_free;
    logic                     advance;
    logic                     out_of_range;
    logic                     new_msg;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         idx_plus1;
    logic [CNT_W-1:0]         cnt_upd;
    logic [CNT_W-1:0]         tot_upd;
    logic [IDX_W-1:0]         hi_upd;
    logic                     bad;
    logic                     dup;

    assign out_free   = !result_valid_reg || result_ready;
    assign advance    = hold_valid_reg && out_free;
    assign frag_ready = !hold_valid_reg || out_free;

    assign idx          = hold_reg.frag_index[IDX_W-1:0];
    assign idx_plus1    = {1'b0, idx} + CNT_W'(1);
    assign out_of_range = hold_reg.frag_index >= FIDX_W'(MAX_FRAGMENTS);
    assign new_msg      = !have_reg || (hold_reg.message_id != cur_id_reg);

    assign bad = ((total_reg != '0) && ({1'b0, idx} >= total_reg))
              || (hold_reg.is_final && (total_reg != '0) && (idx_plus1 != total_reg))
              || (hold_reg.is_final && (count_reg != '0) && (highest_reg > idx));
    assign dup = map_reg[idx];

    always_comb
    begin
        have_next    = have_reg;
        map_next     = map_reg;
        count_next   = count_reg;
        highest_next = highest_reg;
        total_next   = total_reg;
        cnt_upd      = count_reg;
        tot_upd      = total_reg;
        hi_upd       = highest_reg;
        result_next.status         = ST_OK;
        result_next.arrived_count  = count_reg;
        result_next.expected_total = total_reg;
        if (out_of_range)
        begin
            result_next.status = ST_RANGE;
        end
        else if (!new_msg && bad)
        begin
            result_next.status = ST_BAD;
        end
        else if (!new_msg && dup)
        begin
            result_next.status = ST_DUP;
        end
        else
        begin
            if (new_msg)
            begin
                map_next = '0;
                cnt_upd  = CNT_W'(1);
                hi_upd   = idx;
                tot_upd  = '0;
            end
            else
            begin
                cnt_upd = count_reg + CNT_W'(1);
                if ((count_reg == '0) || (idx > highest_reg))
                begin
                    hi_upd = idx;
                end
            end
            map_next[idx] = 1'b1;
            if (hold_reg.is_final)
            begin
                tot_upd = idx_plus1;
            end
            have_next = 1'b1;
            if ((tot_upd != '0) && (cnt_upd == tot_upd))
            begin
                result_next.status         = ST_DONE;
                result_next.arrived_count  = tot_upd;
                result_next.expected_total = tot_upd;
                map_next     = '0;
                count_next   = '0;
                highest_next = '0;
                total_next   = '0;
            end
            else
            begin
                result_next.arrived_count  = cnt_upd;
                result_next.expected_total = tot_upd;
                count_next   = cnt_upd;
                highest_next = hi_upd;
                total_next   = tot_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            have_reg         <= 1'b0;
            cur_id_reg       <= '0;
            map_reg          <= '0;
            count_reg        <= '0;
            highest_reg      <= '0;
            total_reg        <= '0;
        end
        else
        begin
            if (frag_ready)
            begin
                hold_valid_reg <= frag_valid;
            end
            if (out_free)
            begin
                result_valid_reg <= hold_valid_reg;
            end
            if (advance)
            begin
                have_reg    <= have_next;
                map_reg     <= map_next;
                count_reg   <= count_next;
                highest_reg <= highest_next;
                total_reg   <= total_next;
                if (!out_of_range && new_msg)
                begin
                    cur_id_reg <= hold_reg.message_id;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frag_ready && frag_valid)
        begin
            hold_reg <= frag;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `FRT_ASSERT_NOW(a_count_matches_map, 1'b1, count_reg == CNT_W'($countones(map_reg)))
    `FRT_ASSERT_NOW(a_count_below_total, total_reg != '0, count_reg < total_reg)
    `FRT_ASSERT_NEXT(a_done_clears, advance && (result_next.status == ST_DONE),
        (count_reg == '0) && (total_reg == '0) && (map_reg == '0))
    `FRT_ASSERT_NEXT(a_reject_holds_state,
        advance && (result_next.status != ST_OK) && (result_next.status != ST_DONE),
        $stable(map_reg) && $stable(count_reg) && $stable(total_reg))

endmodule

`default_nettype wire

### bench/tb_fragment_reassembly_tracker_top.sv
// Testbench for the fragment reassembly tracker: directed and random fragment headers checked against a model.
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker_top;
    import frt_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    frag_valid = 1'b0;
    logic    frag_ready;
    frag_t   frag = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    frag_t       header_q[$];
    result_t     outcome_q[$];
    result_t     expected_r;
    int          sent_cnt = 0;
    int          mismatches = 0;
    logic [63:0] last_id = '0;

    logic            have_msg = 1'b0;
    logic [63:0]     cur_id = '0;
    logic [63:0]     seen_map = '0;
    int              got_cnt = 0;
    int              top_idx = 0;
    int              want_total = 0;

    fragment_reassembly_tracker_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .frag_valid   (frag_valid),
        .frag_ready   (frag_ready),
        .frag         (frag),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic logic steady();
        return sent_cnt >= 300 && sent_cnt < 450;
    endfunction

    function automatic void post_outcome(status_t s, int cnt, int total);
        result_t r;
        r.status = s;
        r.arrived_count = CNT_W'(cnt);
        r.expected_total = CNT_W'(total);
        outcome_q = {outcome_q, r};
    endfunction

    function automatic void track_fragment(frag_t f);
        int idx;
        idx = int'(f.frag_index);
        if (idx >= MAX_FRAGMENTS)
        begin
            post_outcome(ST_RANGE, got_cnt, want_total);
            return;
        end
        if (!have_msg || f.message_id != cur_id)
        begin
            have_msg = 1'b1;
            cur_id = f.message_id;
            seen_map = '0;
            seen_map[idx] = 1'b1;
            got_cnt = 1;
            top_idx = idx;
            want_total = 0;
        end
        else
        begin
            if (want_total != 0 && idx >= want_total)
            begin
                post_outcome(ST_BAD, got_cnt, want_total);
                return;
            end
            if (f.is_final && ((want_total != 0 && idx + 1 != want_total)
                               || (got_cnt != 0 && top_idx > idx)))
            begin
                post_outcome(ST_BAD, got_cnt, want_total);
                return;
            end
            if (seen_map[idx])
            begin
                post_outcome(ST_DUP, got_cnt, want_total);
                return;
            end
            seen_map[idx] = 1'b1;
            if (got_cnt == 0 || idx > top_idx)
                top_idx = idx;
            got_cnt++;
        end
        if (f.is_final)
            want_total = idx + 1;
        if (want_total != 0 && got_cnt == want_total)
        begin
            post_outcome(ST_DONE, want_total, want_total);
            seen_map = '0;
            got_cnt = 0;
            top_idx = 0;
            want_total = 0;
        end
        else
            post_outcome(ST_OK, got_cnt, want_total);
    endfunction

    task automatic push_header(input logic [63:0] id, input int idx, input logic fin);
        frag_t f;
        f.message_id = id;
        f.frag_index = FIDX_W'(idx);
        f.is_final = fin;
        header_q = {header_q, f};
    endtask

    task automatic queue_message(input logic [63:0] id, input int n);
        int order[MAX_FRAGMENTS];
        int j;
        int tmp;
        int roll;
        for (int k = 0; k < n; k++)
            order[k] = k;
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                push_header(id, $urandom_range(MAX_FRAGMENTS, 32767),
                            1'($urandom_range(0, 1)));
            else if (roll < 8 && k > 0)
                push_header(id, order[$urandom_range(0, k - 1)], 1'($urandom_range(0, 1)));
            else if (roll < 11)
                push_header(id, $urandom_range(0, MAX_FRAGMENTS - 1), 1'b1);
            else if (roll < 13 && n < MAX_FRAGMENTS)
                push_header(id, $urandom_range(n, MAX_FRAGMENTS - 1),
                            1'($urandom_range(0, 1)));
            else if (roll < 15)
                return;
            push_header(id, order[k], order[k] == n - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frag_valid && frag_ready)
            begin
                track_fragment(frag);
                sent_cnt++;
            end
            if (!frag_valid || frag_ready)
            begin
                if (header_q.size() != 0 && (steady() || $urandom_range(0, 99) >= 14))
                begin
                    frag <= header_q.pop_front();
                    frag_valid <= 1'b1;
                end
                else
                    frag_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                mismatches++;
            end
            else
            begin
                expected_r = outcome_q.pop_front();
                if (result.status !== expected_r.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, expected_r.status, result.status);
                    mismatches++;
                end
                if (result.arrived_count !== expected_r.arrived_count)
                begin
                    $display("%0t: arrived_count expected %0d, got %0d",
                             $time, expected_r.arrived_count, result.arrived_count);
                    mismatches++;
                end
                if (result.expected_total !== expected_r.expected_total)
                begin
                    $display("%0t: expected_total expected %0d, got %0d",
                             $time, expected_r.expected_total, result.expected_total);
                    mismatches++;
                end
            end
        end
        result_ready <= steady() || $urandom_range(0, 99) >= 14;
    end

    initial
    begin : stimulus
        logic [63:0] id;
        int          roll;
        int          n;

        push_header(64'd0, MAX_FRAGMENTS, 1'b0);
        push_header(64'd0, 32767, 1'b1);
        push_header(64'd0, 0, 1'b1);
        push_header(64'd0, 0, 1'b0);
        push_header(64'd0, 0, 1'b0);
        push_header(64'd0, 2, 1'b1);
        push_header(64'd0, 5, 1'b0);
        push_header(64'd0, 1, 1'b1);
        push_header(64'd0, 2, 1'b1);
        push_header(64'd0, 1, 1'b0);
        push_header('1, 63, 1'b0);
        push_header('1, 10, 1'b1);
        push_header('1, 63, 1'b1);
        push_header('1, 100, 1'b0);
        push_header('1, 0, 1'b0);
        push_header(64'h5555_5555_5555_5555, 63, 1'b1);
        push_header(64'hAAAA_AAAA_AAAA_AAAA, 5, 1'b0);
        push_header(64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b1);
        push_header(64'hAAAA_AAAA_AAAA_AAAA, 3, 1'b1);
        push_header(64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);

        while (header_q.size() < 750)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                push_header({$urandom, $urandom}, $urandom_range(0, 32767),
                            1'($urandom_range(0, 1)));
                continue;
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
                id = last_id;
            else if (roll < 40)
                id = 64'($urandom_range(0, 255));
            else
                id = {$urandom, $urandom};
            last_id = id;
            roll = $urandom_range(0, 99);
            if (roll < 80)
                n = $urandom_range(1, 8);
            else if (roll < 98)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(56, MAX_FRAGMENTS);
            queue_message(id, n);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (header_q.size() != 0 || frag_valid)
            @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("[fragment_reassembly_tracker_top] OK");
        else
            $display("[fragment_reassembly_tracker_top] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[fragment_reassembly_tracker_top] ERROR");
        $finish;
    end

endmodule
